// ===== hdl/sorted_table_binary_search_top_assert.svh =====
// Assertion macros used by the checker file of the sorted-table search block.
// Each macro expects signals named clk and rst in the scope where it is used.
`ifndef SORTED_TABLE_BINARY_SEARCH_TOP_ASSERT_SVH
`define SORTED_TABLE_BINARY_SEARCH_TOP_ASSERT_SVH

// Same-cycle implication, checked outside reset.
`define STS_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked outside reset.
`define STS_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== hdl/sts_pkg.sv =====
package sts_pkg;

  // Field widths of the beats and of the configuration port.
  localparam int unsigned INDEX_W = 10;
  localparam int unsigned VALUE_W = 32;
  localparam int unsigned LEN_W   = 11;
  localparam int unsigned PADDR_W = 3;
  localparam int unsigned PDATA_W = 32;

  typedef logic [INDEX_W-1:0]        index_t;
  typedef logic signed [VALUE_W-1:0] value_t;
  typedef logic [LEN_W-1:0]          len_t;
  typedef logic [PADDR_W-1:0]        paddr_t;
  typedef logic [PDATA_W-1:0]        pdata_t;

  // Operation carried by an input beat.
  typedef enum logic {
    OP_WRITE  = 1'b0,
    OP_SEARCH = 1'b1
  } opcode_t;

  // Register word index, taken from paddr above the byte offset.
  localparam logic REG_TABLE_LENGTH = 1'b0;

endpackage

// ===== hdl/sts_mem.sv =====
module sts_mem #(
  parameter int unsigned DEPTH = 1024,
  localparam int unsigned AW = $clog2(DEPTH)
) (
  input  logic            clk,
  input  logic            wr_en,
  input  logic [AW-1:0]   wr_addr,
  input  sts_pkg::value_t wr_data,
  input  logic            rd_en,
  input  logic [AW-1:0]   rd_addr,
  output sts_pkg::value_t rd_data
);
  import sts_pkg::*;

  value_t mem [DEPTH];

  // One write port.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // One read port with registered data.
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

// ===== hdl/sts_search.sv =====
module sts_search #(
  parameter int unsigned DEPTH = 1024,
  localparam int unsigned AW = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             rst,
  input  sts_pkg::len_t    table_length,
  input  logic             in_valid,
  output logic             in_ready,
  input  sts_pkg::opcode_t opcode,
  input  sts_pkg::index_t  entry_index,
  input  sts_pkg::value_t  entry_value,
  input  sts_pkg::value_t  search_key,
  output logic             out_valid,
  input  logic             out_ready,
  output logic             found,
  output sts_pkg::index_t  position,
  output logic             wr_en,
  output logic [AW-1:0]    wr_addr,
  output sts_pkg::value_t  wr_data,
  output logic             rd_en,
  output logic [AW-1:0]    rd_addr,
  input  sts_pkg::value_t  rd_data
);
  import sts_pkg::*;

  // Window bounds run from 0 to DEPTH, one bit wider than an address.
  localparam int unsigned CW = AW + 1;

  typedef enum logic [3:0] {
    ST_IDLE  = 4'b0001,
    ST_PROBE = 4'b0010,
    ST_LAST  = 4'b0100,
    ST_EMIT  = 4'b1000
  } state_t;

  state_t          state, state_next;
  logic [CW-1:0]   lo, lo_next, hi, hi_next;
  logic [AW-1:0]   mid, mid_next;
  value_t          key, key_next;
  logic            res_found, res_found_next;
  index_t          res_pos, res_pos_next;
  logic            load_out;
  logic [CW-1:0]   len_sat;
  logic [CW-1:0]   lo_upd, hi_upd;
  logic            accept, out_free, key_below;

  // Middle of the half-open window [a, b), rounded down as in the closed form.
  function automatic logic [AW-1:0] mid_of(input logic [CW-1:0] a, input logic [CW-1:0] b);
    logic [CW:0] sum;
    sum = {1'b0, a} + {1'b0, b} - 1'b1;
    return sum[AW:1];
  endfunction

  assign accept   = in_valid && in_ready;
  assign in_ready = (state == ST_IDLE);
  assign out_free = !out_valid || out_ready;

  // A length beyond the table depth is clamped to the depth.
  assign len_sat = (32'(table_length) > 32'(DEPTH)) ? CW'(DEPTH) : CW'(table_length);

  // Write beats go straight to the memory write port.
  assign wr_en   = accept && (opcode == OP_WRITE) && (32'(entry_index) < 32'(DEPTH));
  assign wr_addr = AW'(entry_index);
  assign wr_data = entry_value;

  // One probe test per cycle: is the key below the entry just read?
  assign key_below = key < rd_data;
  assign lo_upd    = key_below ? lo : ({1'b0, mid} + CW'(1));
  assign hi_upd    = key_below ? {1'b0, mid} : hi;

  // Sequencer: probe, read the entry below the window, emit the result.
  always_comb begin
    state_next     = state;
    lo_next        = lo;
    hi_next        = hi;
    mid_next       = mid;
    key_next       = key;
    res_found_next = res_found;
    res_pos_next   = res_pos;
    rd_en          = 1'b0;
    rd_addr        = mid;
    load_out       = 1'b0;
    case (state)
      ST_IDLE: begin
        if (accept && (opcode == OP_SEARCH)) begin
          key_next = search_key;
          if (len_sat == '0) begin
            res_found_next = 1'b0;
            res_pos_next   = '0;
            state_next     = ST_EMIT;
          end else begin
            lo_next    = '0;
            hi_next    = len_sat;
            mid_next   = mid_of('0, len_sat);
            rd_en      = 1'b1;
            rd_addr    = mid_next;
            state_next = ST_PROBE;
          end
        end
      end
      ST_PROBE: begin
        lo_next = lo_upd;
        hi_next = hi_upd;
        if (lo_upd < hi_upd) begin
          mid_next = mid_of(lo_upd, hi_upd);
          rd_en    = 1'b1;
          rd_addr  = mid_next;
        end else if (lo_upd == '0) begin
          // The window closed at position zero: nothing below it to compare.
          res_found_next = 1'b0;
          res_pos_next   = '0;
          state_next     = ST_EMIT;
        end else begin
          rd_en      = 1'b1;
          rd_addr    = AW'(lo_upd - CW'(1));
          state_next = ST_LAST;
        end
      end
      ST_LAST: begin
        res_found_next = (rd_data == key);
        res_pos_next   = (rd_data == key) ? INDEX_W'(lo - CW'(1)) : '0;
        if (out_free) begin
          load_out   = 1'b1;
          state_next = ST_IDLE;
        end else begin
          state_next = ST_EMIT;
        end
      end
      ST_EMIT: begin
        if (out_free) begin
          load_out   = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  // Control state.
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (load_out) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // Window, key and result registers.
  always_ff @(posedge clk) begin
    lo        <= lo_next;
    hi        <= hi_next;
    mid       <= mid_next;
    key       <= key_next;
    res_found <= res_found_next;
    res_pos   <= res_pos_next;
    if (load_out) begin
      found    <= res_found_next;
      position <= res_pos_next;
    end
  end

endmodule

// ===== hdl/sorted_table_binary_search_top.sv =====
// Binary search over a sorted table of signed 32-bit entries held in one synchronous RAM.
// A write beat (opcode 0) stores entry_value at entry_index and returns no beat; an index
// at or beyond TABLE_DEPTH is dropped. A search beat (opcode 1) probes the first
// table_length entries, one RAM read per cycle, then reads the entry just below the
// closed window and returns found and the position of the last equal entry (position is 0
// when not found). The block takes no new beat while a search runs, also while its result
// waits for a free output register; an empty table answers without a RAM read. The
// table is not checked for order, and every entry a search can touch must have been
// written first. table_length sits at byte address 0 and is clamped to TABLE_DEPTH when
// larger; it should be written only while no search is open.
module sorted_table_binary_search_top #(
  parameter int unsigned TABLE_DEPTH = 1024
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             psel,
  input  logic             penable,
  input  logic             pwrite,
  input  sts_pkg::paddr_t  paddr,
  input  sts_pkg::pdata_t  pwdata,
  output sts_pkg::pdata_t  prdata,
  output logic             pready,
  input  logic             in_valid,
  output logic             in_ready,
  input  sts_pkg::opcode_t opcode,
  input  sts_pkg::index_t  entry_index,
  input  sts_pkg::value_t  entry_value,
  input  sts_pkg::value_t  search_key,
  output logic             out_valid,
  input  logic             out_ready,
  output logic             found,
  output sts_pkg::index_t  position
);
  import sts_pkg::*;

  localparam int unsigned AW = $clog2(TABLE_DEPTH);

  len_t          table_length;
  logic          wr_en, rd_en;
  logic [AW-1:0] wr_addr, rd_addr;
  value_t        wr_data, rd_data;
  logic          reg_sel;

  // Configuration register, written in the access phase.
  assign pready  = 1'b1;
  assign reg_sel = (paddr[2] == REG_TABLE_LENGTH);

  always_ff @(posedge clk) begin
    if (rst) begin
      table_length <= '0;
    end else if (psel && penable && pwrite && pready && reg_sel) begin
      table_length <= pwdata[LEN_W-1:0];
    end
  end

  assign prdata = reg_sel ? PDATA_W'(table_length) : '0;

  sts_search #(
    .DEPTH (TABLE_DEPTH)
  ) u_search (
    .clk          (clk),
    .rst          (rst),
    .table_length (table_length),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .opcode       (opcode),
    .entry_index  (entry_index),
    .entry_value  (entry_value),
    .search_key   (search_key),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .found        (found),
    .position     (position),
    .wr_en        (wr_en),
    .wr_addr      (wr_addr),
    .wr_data      (wr_data),
    .rd_en        (rd_en),
    .rd_addr      (rd_addr),
    .rd_data      (rd_data)
  );

  sts_mem #(
    .DEPTH (TABLE_DEPTH)
  ) u_mem (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

endmodule

// ===== hdl/sts_checker.sv =====
`include "sorted_table_binary_search_top_assert.svh"

module sts_checker (
  input logic             clk,
  input logic             rst,
  input logic             in_valid,
  input logic             in_ready,
  input sts_pkg::opcode_t opcode,
  input logic             out_valid,
  input logic             out_ready,
  input logic             found,
  input sts_pkg::index_t  position
);
  import sts_pkg::*;

  // A stalled result beat holds its payload.
  `STS_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(found) && $stable(position), "result beat changed while stalled")

  // A miss always reports position zero.
  `STS_ASSERT_NOW(a_miss_pos, out_valid && !found, position == '0, "miss reported a nonzero position")

  // A search keeps the input side closed in the cycle after it is taken.
  `STS_ASSERT_NEXT(a_search_busy, in_valid && in_ready && opcode == OP_SEARCH, !in_ready, "input taken while a search runs")

  // A write beat never produces a result beat.
  `STS_ASSERT_NEXT(a_write_silent, in_valid && in_ready && opcode == OP_WRITE && !out_valid, !out_valid, "write beat produced a result")

endmodule

bind sorted_table_binary_search_top sts_checker u_sts_checker (.*);

// ===== sim/sorted_table_binary_search_top_tb.sv =====
`default_nettype none

module sorted_table_binary_search_top_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import sts_pkg::*;

  localparam int unsigned TABLE_DEPTH   = 1024;
  localparam int unsigned SETTLE_CYCLES = 32;
  localparam int unsigned CYCLE_LIMIT   = 500000;
  localparam int unsigned PHASE_BEATS   = 80;
  localparam int unsigned RANDOM_PHASES = 8;
  localparam longint      VALUE_MIN     = -64'sd2147483648;
  localparam longint      VALUE_MAX     = 64'sd2147483647;

  // One input beat as the sender holds it.
  typedef struct {
    opcode_t op;
    index_t  idx;
    value_t  val;
    value_t  key;
  } table_beat_t;

  // One search answer.
  typedef struct {
    logic   hit;
    index_t pos;
  } search_answer_t;

  logic    clk = 1'b0;
  logic    rst = 1'b1;
  logic    psel = 1'b0;
  logic    penable = 1'b0;
  logic    pwrite = 1'b0;
  paddr_t  paddr = '0;
  pdata_t  pwdata = '0;
  pdata_t  prdata;
  logic    pready;
  logic    in_valid = 1'b0;
  logic    in_ready;
  opcode_t opcode = OP_WRITE;
  index_t  entry_index = '0;
  value_t  entry_value = '0;
  value_t  search_key = '0;
  logic    out_valid;
  logic    out_ready = 1'b0;
  logic    found;
  index_t  position;

  // Beats waiting to be sent and answers waiting to arrive.
  table_beat_t    pending_beats[$];
  search_answer_t expected_answers[$];

  // Table contents as the predictor sees them at acceptance time.
  value_t      table_mem [TABLE_DEPTH];
  len_t        table_len_cfg = '0;
  // Table contents as planned while the stimulus is built.
  value_t      plan_mem [TABLE_DEPTH];
  int unsigned plan_len = 0;

  int unsigned send_idle_pct = 0;
  int unsigned recv_stall_pct = 0;
  int unsigned mismatch_count = 0;
  int unsigned cycle_count = 0;
  logic        in_took = 1'b0;

  sorted_table_binary_search_top #(
    .TABLE_DEPTH(TABLE_DEPTH)
  ) DUT (
    .clk(clk),
    .rst(rst),
    .psel(psel),
    .penable(penable),
    .pwrite(pwrite),
    .paddr(paddr),
    .pwdata(pwdata),
    .prdata(prdata),
    .pready(pready),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .opcode(opcode),
    .entry_index(entry_index),
    .entry_value(entry_value),
    .search_key(search_key),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .found(found),
    .position(position)
  );

  always #4 clk = ~clk;

  // Watchdog on the whole run.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  // Sender and receiver, both driven on the falling edge.
  always @(negedge clk) begin : drive_beats
    table_beat_t next_beat;
    if (rst) begin
      in_valid <= 1'b0;
      out_ready <= 1'b0;
    end else begin
      if (!in_valid || in_took) begin
        if (pending_beats.size() != 0 && $urandom_range(99, 0) >= send_idle_pct) begin
          next_beat = pending_beats.pop_front();
          in_valid <= 1'b1;
          opcode <= next_beat.op;
          entry_index <= next_beat.idx;
          entry_value <= next_beat.val;
          search_key <= next_beat.key;
        end else begin
          in_valid <= 1'b0;
        end
      end
      out_ready <= ($urandom_range(99, 0) >= recv_stall_pct);
    end
  end

  // Check result beats, track accepted writes and predict the answer of every accepted search beat.
  always @(posedge clk) begin : watch_beats
    search_answer_t want;
    search_answer_t got;
    int lo;
    int hi;
    int mid;
    if (rst) begin
      in_took <= 1'b0;
    end else begin
      in_took <= in_valid && in_ready;

      if (out_valid && out_ready) begin
        if (expected_answers.size() == 0) begin
          $error("unexpected result beat: found=%0b position=%0d", found, position);
          mismatch_count++;
        end else begin
          want = expected_answers.pop_front();
          if (found !== want.hit) begin
            $error("found: expected %0b, actual %0b", want.hit, found);
            mismatch_count++;
          end
          if (position !== want.pos) begin
            $error("position: expected %0d, actual %0d", want.pos, position);
            mismatch_count++;
          end
        end
      end

      if (in_valid && in_ready) begin
        if (opcode == OP_WRITE) begin
          table_mem[entry_index] = entry_value;
        end else begin
          // One "key below entry" test per probe, then a look just below the window.
          lo = 0;
          hi = (table_len_cfg > TABLE_DEPTH) ? TABLE_DEPTH - 1 : int'(table_len_cfg) - 1;
          while (lo <= hi) begin
            mid = (lo + hi) / 2;
            if (search_key < table_mem[mid]) hi = mid - 1;
            else lo = mid + 1;
          end
          got.hit = 1'b0;
          got.pos = '0;
          if (lo > 0 && table_mem[lo - 1] == search_key) begin
            got.hit = 1'b1;
            got.pos = index_t'(lo - 1);
          end
          expected_answers.push_back(got);
        end
      end
    end
  end

  // Queue a write beat; the unused key field carries random bits.
  task automatic queue_write(input index_t idx, input value_t val);
    table_beat_t b;
    b.op = OP_WRITE;
    b.idx = idx;
    b.val = val;
    b.key = value_t'($urandom());
    plan_mem[idx] = val;
    pending_beats.push_back(b);
  endtask

  // Queue a search beat; the unused index and value fields carry random bits.
  task automatic queue_search(input value_t key);
    table_beat_t b;
    b.op = OP_SEARCH;
    b.idx = index_t'($urandom_range(TABLE_DEPTH - 1, 0));
    b.val = value_t'($urandom());
    b.key = key;
    pending_beats.push_back(b);
  endtask

  // Wait until every beat is sent and answered, then let a trailing write settle.
  task automatic wait_until_idle();
    do @(negedge clk);
    while (pending_beats.size() != 0 || in_valid || expected_answers.size() != 0);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  // Register write: setup cycle, then access cycle.
  task automatic set_table_length(input int unsigned len);
    @(negedge clk);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= paddr_t'({REG_TABLE_LENGTH, 2'b00});
    pwdata <= pdata_t'(len);
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk);
    while (!pready);
    table_len_cfg = len_t'(len);
    plan_len = (len > TABLE_DEPTH) ? TABLE_DEPTH : len;
    @(negedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    @(posedge clk);
  endtask

  initial begin : stimulus
    longint      cur;
    longint      lo_bound;
    longint      hi_bound;
    int unsigned pick;
    int unsigned roll;
    int unsigned len_choice;
    value_t      val;

    repeat (4) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Empty table straight out of reset: nothing is read, nothing is found.
    queue_search(value_t'(VALUE_MIN));
    queue_search(value_t'(VALUE_MAX));
    queue_search('0);

    // Fill the whole table in ascending order with runs of duplicates. The first
    // entry sits above the most negative value so that a key can fall below all.
    cur = VALUE_MIN + longint'($urandom_range(4096, 1));
    for (int i = 0; i < TABLE_DEPTH - 1; i++) begin
      queue_write(index_t'(i), value_t'(cur));
      if ($urandom_range(3, 0) != 0) cur = cur + longint'($urandom_range(8000000, 1));
      if (cur > VALUE_MAX - 1) cur = VALUE_MAX - 1;
    end
    queue_write(index_t'(TABLE_DEPTH - 1), value_t'(VALUE_MAX));
    wait_until_idle();

    // Full table: below everything, the top entry, duplicates, gaps.
    set_table_length(TABLE_DEPTH);
    queue_search(value_t'(VALUE_MIN));
    queue_search(value_t'(VALUE_MAX));
    queue_search(plan_mem[0]);
    queue_search(plan_mem[511]);
    queue_search(value_t'(longint'(plan_mem[511]) + 1));
    queue_write('0, value_t'(VALUE_MIN));
    queue_search(value_t'(VALUE_MIN));
    wait_until_idle();

    // One entry in use.
    set_table_length(1);
    queue_search(plan_mem[0]);
    queue_search(value_t'(VALUE_MAX));
    queue_search(plan_mem[1]);
    wait_until_idle();

    // Length above the table depth is clamped.
    set_table_length(2047);
    queue_search(value_t'(VALUE_MAX));
    queue_search(plan_mem[1022]);
    wait_until_idle();

    // Explicitly empty table.
    set_table_length(0);
    queue_search(plan_mem[5]);
    wait_until_idle();

    // Random phases, each with a chosen length and one of four idling patterns. Most searches
    // look for keys in or next to the table; a few writes break the order.
    for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
      case (phase)
        0: len_choice = TABLE_DEPTH;
        1: len_choice = 2;
        2: len_choice = 2047;
        3: len_choice = TABLE_DEPTH - 1;
        4: len_choice = 3;
        5: len_choice = 1;
        default: len_choice = $urandom_range(2047, 0);
      endcase
      case (phase % 4)
        0: begin
          send_idle_pct = 0;
          recv_stall_pct = 0;
        end
        1: begin
          send_idle_pct = 59;
          recv_stall_pct = 0;
        end
        2: begin
          send_idle_pct = 0;
          recv_stall_pct = 59;
        end
        default: begin
          send_idle_pct = 29;
          recv_stall_pct = 29;
        end
      endcase
      set_table_length(len_choice);

      for (int n = 0; n < PHASE_BEATS; n++) begin
        roll = $urandom_range(99, 0);
        if (plan_len != 0 && $urandom_range(9, 0) != 0) pick = $urandom_range(plan_len - 1, 0);
        else pick = $urandom_range(TABLE_DEPTH - 1, 0);
        if (roll < 10) begin
          // Write that keeps the order, where the neighbors still allow it.
          lo_bound = (pick > 0) ? longint'(plan_mem[pick - 1]) : VALUE_MIN;
          hi_bound = (pick < TABLE_DEPTH - 1) ? longint'(plan_mem[pick + 1]) : VALUE_MAX;
          if (hi_bound >= lo_bound)
            val = value_t'(lo_bound + longint'($urandom_range(32'(hi_bound - lo_bound), 0)));
          else
            val = plan_mem[pick];
          queue_write(index_t'(pick), val);
        end else if (roll < 12) begin
          queue_write(index_t'(pick), value_t'($urandom()));
        end else if (roll < 55) begin
          queue_search(plan_mem[pick]);
        end else if (roll < 75) begin
          if ($urandom_range(1, 0) != 0) queue_search(plan_mem[pick] + value_t'(1));
          else queue_search(plan_mem[pick] - value_t'(1));
        end else if (roll < 90) begin
          queue_search(value_t'($urandom()));
        end else begin
          case ($urandom_range(2, 0))
            0: queue_search(value_t'(VALUE_MIN));
            1: queue_search(value_t'(VALUE_MAX));
            default: queue_search('0);
          endcase
        end
      end
      wait_until_idle();
    end

    if (mismatch_count == 0 && expected_answers.size() == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule

`default_nettype wire

// ===== sorted_table_binary_search_top.f =====
+incdir+hdl
hdl/sts_pkg.sv
hdl/sts_mem.sv
hdl/sts_search.sv
hdl/sorted_table_binary_search_top.sv
hdl/sts_checker.sv
sim/sorted_table_binary_search_top_tb.sv
